[hdl/neural_activation_unit_defines.svh]
// Assertion macros for the activation unit.
// Expects clk and arst_n in the scope of each use.
`ifndef NEURAL_ACTIVATION_UNIT_DEFINES_SVH
`define NEURAL_ACTIVATION_UNIT_DEFINES_SVH

// Same-cycle implication under reset.
`define NAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define NAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/nau_pkg.sv]
// Shared types, codes and the whole-unit exponential scaling used for the sigmoid breakpoints.
// No dependencies.
`default_nettype none

package nau_pkg;

	typedef logic signed [15:0] sample_t;

	typedef enum logic [1:0] {
		MODE_FWD = 2'd0,
		MODE_DX  = 2'd1,
		MODE_DY  = 2'd2,
		MODE_OFF = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		FK_HEAVISIDE = 3'd0,
		FK_IDENTITY  = 3'd1,
		FK_SIGMOID   = 3'd2,
		FK_RELU      = 3'd3,
		FK_LEAKY     = 3'd4
	} fn_kind_t;

	typedef enum logic {
		REG_KIND = 1'b0,
		REG_LEAK = 1'b1
	} reg_idx_t;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	localparam longint EXP_M1_Q30 = 64'sd395007542;

	// scale a Q30 value by e^-1 once per whole unit of n, at most 16 times
	function automatic longint exp_whole(input longint acc, input longint n);
		longint a;
		int i;
		a = acc;
		for (i = 0; i < 16; i++) begin
			if (longint'(i) < n)
				a = (a * EXP_M1_Q30) >>> 30;
		end
		return a;
	endfunction

endpackage

`default_nettype wire

[hdl/nau_in_if.sv]
// Input sample channel of the activation unit.
// Depends on nau_pkg.
`default_nettype none

interface nau_in_if;
	import nau_pkg::*;

	logic    valid;
	logic    ready;
	mode_t   mode;
	sample_t sample_in;

	modport source (output valid, output mode, output sample_in, input ready);
	modport sink (input valid, input mode, input sample_in, output ready);
endinterface

`default_nettype wire

[hdl/nau_out_if.sv]
// Result channel of the activation unit.
// Depends on nau_pkg.
`default_nettype none

interface nau_out_if;
	import nau_pkg::*;

	logic    valid;
	logic    ready;
	sample_t result_out;
	logic    saturated;

	modport source (output valid, output result_out, output saturated, input ready);
	modport sink (input valid, input result_out, input saturated, output ready);
endinterface

`default_nettype wire

[hdl/neural_activation_unit.sv]
// Activation unit: five-stage pipeline, one result per sample. One sample is accepted and one
// beat passed per cycle except while a full pipe waits on out_ch.ready; each stage holds one
// beat and fills bubbles independently. A beat moves through stage registers s1 to s5 in order.
// Stages: clamp/segment + leak product, table read + slope product, interpolate + round,
// derivative product, select + clip into the output register.
// arst_n clears all stage valid bits and sets function_kind to identity and leak_rate to 0.
`default_nettype none
`include "neural_activation_unit_defines.svh"

module neural_activation_unit #(
	parameter int SIGMOID_SEGMENTS = 64,
	parameter int FRACTION_BITS    = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	nau_in_if.sink                      in_ch,
	nau_out_if.source                   out_ch,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import nau_pkg::*;

	localparam int F     = FRACTION_BITS;
	localparam int SEG   = SIGMOID_SEGMENTS;
	localparam int XW    = (F + 6 > 18) ? F + 6 : 18;
	localparam int PW    = F + 5;
	localparam int IW    = $clog2(SEG + 1);
	localparam int UW    = PW + IW;
	localparam int TW    = UW - (F + 4);
	localparam int RMW   = F + 5;
	localparam int DW    = 33 + RMW;
	localparam int SVW   = F + 2;
	localparam int YW    = (F + 3 > 17) ? F + 3 : 17;
	localparam int OW    = YW + 1;
	localparam int PRW   = YW + OW;
	localparam int RW    = PRW;

	localparam logic signed [XW-1:0]  LIM      = XW'(longint'(8) << F);
	localparam logic signed [XW-1:0]  NLIM     = -LIM;
	localparam logic [RMW-1:0]        REM_FULL = RMW'(longint'(1) << (F + 4));
	localparam logic signed [31:0]    LHALF    = 32'(longint'(1) << (F - 1));
	localparam logic signed [31:0]    VHALF    = 32'(longint'(1) << (29 - F));
	localparam logic signed [OW-1:0]  ONE_O    = OW'(longint'(1) << F);
	localparam logic signed [PRW-1:0] PHALF    = PRW'(longint'(1) << (F - 1));
	localparam logic signed [RW-1:0]  ONE_R    = RW'(longint'(1) << F);
	localparam logic signed [RW-1:0]  R_MAX    = RW'(SAMPLE_MAX);
	localparam logic signed [RW-1:0]  R_MIN    = RW'(SAMPLE_MIN);
	localparam logic signed [SVW-1:0] ONE_SV   = SVW'(longint'(1) << F);

	// ---------------- sigmoid breakpoints, Q30 ----------------
	logic [30:0] sig_tbl [SEG+1];

	for (genvar k = 0; k <= SEG; k++) begin : g_tbl
		localparam longint T = (longint'(k) * (longint'(16) << 20)) / SIGMOID_SEGMENTS
			- (longint'(8) << 20);
		// evaluate at |T| and mirror about one half for negative positions
		localparam longint TA  = (T >= 0) ? T : -T;
		localparam longint FR  = TA & ((longint'(1) << 20) - longint'(1));
		// series terms of exp(-FR) in Q30
		localparam longint E1  = (((longint'(1) << 30) * FR) >>> 20) / longint'(1);
		localparam longint E2  = ((E1 * FR) >>> 20) / longint'(2);
		localparam longint E3  = ((E2 * FR) >>> 20) / longint'(3);
		localparam longint E4  = ((E3 * FR) >>> 20) / longint'(4);
		localparam longint E5  = ((E4 * FR) >>> 20) / longint'(5);
		localparam longint E6  = ((E5 * FR) >>> 20) / longint'(6);
		localparam longint E7  = ((E6 * FR) >>> 20) / longint'(7);
		localparam longint E8  = ((E7 * FR) >>> 20) / longint'(8);
		localparam longint E9  = ((E8 * FR) >>> 20) / longint'(9);
		localparam longint E10 = ((E9 * FR) >>> 20) / longint'(10);
		localparam longint E11 = ((E10 * FR) >>> 20) / longint'(11);
		localparam longint E12 = ((E11 * FR) >>> 20) / longint'(12);
		localparam longint E13 = ((E12 * FR) >>> 20) / longint'(13);
		localparam longint E14 = ((E13 * FR) >>> 20) / longint'(14);
		localparam longint E15 = ((E14 * FR) >>> 20) / longint'(15);
		localparam longint ACC0 = (longint'(1) << 30) - E1 + E2 - E3 + E4 - E5 + E6 - E7
			+ E8 - E9 + E10 - E11 + E12 - E13 + E14 - E15;
		localparam longint ACC  = (ACC0 < 0) ? longint'(0) : ACC0;
		localparam longint ACCN = exp_whole(ACC, TA >>> 20);
		localparam longint S    = (longint'(1) << 60) / ((longint'(1) << 30) + ACCN);
		localparam logic [30:0] PT = (T >= 0) ? 31'(S) : 31'((longint'(1) << 30) - S);
		assign sig_tbl[k] = PT;
	end

	// ---------------- configuration registers ----------------
	fn_kind_t       kind_q;
	sample_t        leak_q;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= FK_IDENTITY;
			leak_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_KIND: kind_q <= fn_kind_t'(pwdata[2:0]);
				REG_LEAK: leak_q <= sample_t'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_KIND: prdata = {29'd0, kind_q};
			REG_LEAK: prdata = {{16{leak_q[15]}}, leak_q};
			default:  prdata = '0;
		endcase
	end

	// ---------------- handshake chain ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || out_ch.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ch.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_ch.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: clamp, segment, leak product ----------------
	logic signed [XW-1:0] x_ext, x_clamp;
	logic [PW-1:0]        pos;
	logic [UW-1:0]        upos;
	logic [TW-1:0]        seg_hi;
	logic [IW-1:0]        seg_d;
	logic [RMW-1:0]       rem_d;
	logic signed [31:0]   lprod_d;

	always_comb begin
		x_ext = XW'(in_ch.sample_in);
		if (x_ext > LIM)
			x_clamp = LIM;
		else if (x_ext < NLIM)
			x_clamp = NLIM;
		else
			x_clamp = x_ext;
		pos    = PW'(x_clamp + LIM);
		upos   = UW'(pos) * UW'(SIGMOID_SEGMENTS);
		seg_hi = upos[UW-1:F+4];
		// the top end lands on the last segment with a full remainder
		if (seg_hi >= TW'(SIGMOID_SEGMENTS)) begin
			seg_d = IW'(SIGMOID_SEGMENTS - 1);
			rem_d = REM_FULL;
		end else begin
			seg_d = seg_hi[IW-1:0];
			rem_d = {1'b0, upos[F+3:0]};
		end
		lprod_d = 32'(leak_q) * 32'(in_ch.sample_in);
	end

	mode_t              mode_s1;
	sample_t            x_s1;
	logic [IW-1:0]      seg_s1;
	logic [RMW-1:0]     rem_s1;
	logic signed [31:0] lprod_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			mode_s1  <= in_ch.mode;
			x_s1     <= in_ch.sample_in;
			seg_s1   <= seg_d;
			rem_s1   <= rem_d;
			lprod_s1 <= lprod_d;
		end
	end

	// ---------------- stage 2: table read, slope times remainder, leak rounding ----------------
	logic [30:0]          lo_d, hi_d;
	logic signed [31:0]   diff_d;
	logic signed [DW-1:0] dprod_d;
	logic signed [31:0]   lr_d;

	always_comb begin
		lo_d    = sig_tbl[seg_s1];
		hi_d    = sig_tbl[IW'(seg_s1 + IW'(1))];
		diff_d  = $signed({1'b0, hi_d}) - $signed({1'b0, lo_d});
		dprod_d = DW'(diff_d) * DW'($signed({1'b0, rem_s1}));
		lr_d    = (lprod_s1 + LHALF) >>> F;
	end

	mode_t                mode_s2;
	sample_t              x_s2;
	logic [30:0]          lo_s2;
	logic signed [DW-1:0] dprod_s2;
	logic signed [31:0]   lr_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			mode_s2  <= mode_s1;
			x_s2     <= x_s1;
			lo_s2    <= lo_d;
			dprod_s2 <= dprod_d;
			lr_s2    <= lr_d;
		end
	end

	// ---------------- stage 3: interpolate and round to the output scale ----------------
	logic signed [DW-1:0] adj_d, quo_d;
	logic signed [31:0]   vq_d, vr_d;

	always_comb begin
		// divide by the span, truncating toward zero
		adj_d = dprod_s2 + (dprod_s2[DW-1] ? DW'(REM_FULL - RMW'(1)) : DW'(0));
		quo_d = adj_d >>> (F + 4);
		vq_d  = 32'(quo_d) + $signed({1'b0, lo_s2});
		vr_d  = (vq_d + VHALF) >>> (30 - F);
	end

	mode_t                mode_s3;
	sample_t              x_s3;
	logic signed [SVW-1:0] sv_s3;
	logic signed [31:0]   lr_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			mode_s3 <= mode_s2;
			x_s3    <= x_s2;
			sv_s3   <= SVW'(vr_d);
			lr_s3   <= lr_s2;
		end
	end

	// ---------------- stage 4: derivative product y * (1 - y) ----------------
	logic signed [YW-1:0]  y_d;
	logic signed [OW-1:0]  om_d;
	logic signed [PRW-1:0] dy_d;

	always_comb begin
		y_d  = (mode_s3 == MODE_DY) ? YW'(x_s3) : YW'(sv_s3);
		om_d = ONE_O - OW'(y_d);
		dy_d = PRW'(y_d) * PRW'(om_d);
	end

	mode_t                 mode_s4;
	sample_t               x_s4;
	logic signed [SVW-1:0] sv_s4;
	logic signed [31:0]    lr_s4;
	logic signed [PRW-1:0] dy_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			mode_s4 <= mode_s3;
			x_s4    <= x_s3;
			sv_s4   <= sv_s3;
			lr_s4   <= lr_s3;
			dy_s4   <= dy_d;
		end
	end

	// ---------------- stage 5: select by function, clip ----------------
	logic signed [RW-1:0] dyr_d, xr_d, r_d;
	logic                 xpos_d;
	sample_t              res_d;
	logic                 sat_d;

	always_comb begin
		dyr_d  = (dy_s4 + PHALF) >>> F;
		xr_d   = RW'(x_s4);
		xpos_d = (x_s4 > 16'sd0);
		case (kind_q)
			FK_HEAVISIDE: r_d = (mode_s4 == MODE_FWD && xpos_d) ? ONE_R : RW'(0);
			FK_SIGMOID:   r_d = (mode_s4 == MODE_FWD) ? RW'(sv_s4) : dyr_d;
			FK_RELU: begin
				if (mode_s4 == MODE_FWD)
					r_d = xpos_d ? xr_d : RW'(0);
				else
					r_d = xpos_d ? ONE_R : RW'(0);
			end
			FK_LEAKY: begin
				if (mode_s4 == MODE_FWD)
					r_d = xpos_d ? xr_d : RW'(lr_s4);
				else
					r_d = xpos_d ? ONE_R : RW'(leak_q);
			end
			default:      r_d = (mode_s4 == MODE_FWD) ? xr_d : ONE_R;
		endcase
		// unused mode code drops to zero
		if (mode_s4 == MODE_OFF)
			r_d = RW'(0);
		if (r_d > R_MAX) begin
			res_d = sample_t'(SAMPLE_MAX);
			sat_d = 1'b1;
		end else if (r_d < R_MIN) begin
			res_d = sample_t'(SAMPLE_MIN);
			sat_d = 1'b1;
		end else begin
			res_d = r_d[15:0];
			sat_d = 1'b0;
		end
	end

	sample_t res_s5;
	logic    sat_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			res_s5 <= res_d;
			sat_s5 <= sat_d;
		end
	end

	assign out_ch.valid      = v_s5;
	assign out_ch.result_out = res_s5;
	assign out_ch.saturated  = sat_s5;

	// ---------------- assertions ----------------
	`NAU_ASSERT_NEXT(a_accept_fills_s1, in_ch.valid && in_ch.ready, v_s1,
		"accepted beat did not reach stage 1")
	`NAU_ASSERT_NEXT(a_s1_holds, v_s1 && !rdy2, v_s1 && $stable(x_s1) && $stable(seg_s1),
		"stalled stage 1 beat changed")
	`NAU_ASSERT_NOW(a_sig_range, v_s3, sv_s3 >= SVW'(0) && sv_s3 <= ONE_SV,
		"interpolated sigmoid outside zero to one")
	`NAU_ASSERT_NOW(a_sat_extreme, v_s5 && sat_s5,
		res_s5 == sample_t'(SAMPLE_MAX) || res_s5 == sample_t'(SAMPLE_MIN),
		"saturated flag without a clipped result")

endmodule

`default_nettype wire
